// ===== hdl/llfl_pkg.sv =====
// ----------------------------------------------------------------------------
// llfl_pkg
// Shared widths, codes and control structs of the linked-list node store.
// ----------------------------------------------------------------------------
package llfl_pkg;

	// Default node count of the store
	localparam int NODE_COUNT_DEF = 256;

	// Fixed field widths
	localparam int KEY_W      = 16;
	localparam int PAYLOAD_W  = 32;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 8;

	// Request types
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic                latch_req;
		logic                ins_take_free;
		logic                ins_take_unused;
		logic                pop_free;
		logic                ins_write;
		logic                rm_start;
		logic                rm_advance;
		logic                rm_unlink;
		logic                rm_free;
		logic                set_res;
		logic [STATUS_W-1:0] res_code;
		logic                load_out;
	} llfl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic req_remove;
		logic free_empty;
		logic unused_full;
		logic list_empty;
		logic key_hit;
		logic link_nil;
		logic walk_last;
		logic out_free;
	} llfl_sts_t;

endpackage

// ===== hdl/llfl_req_if.sv =====
// ----------------------------------------------------------------------------
// llfl_req_if
// Request channel: valid/ready handshake with request type, key and payload.
// ----------------------------------------------------------------------------
interface llfl_req_if
	import llfl_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [KEY_W-1:0]     key;
	logic [PAYLOAD_W-1:0] payload;

	modport source (output valid, output req_type, output key, output payload, input ready);
	modport sink   (input valid, input req_type, input key, input payload, output ready);
endinterface

// ===== hdl/llfl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// llfl_rsp_if
// Result channel: valid/ready handshake with status and slot index.
// ----------------------------------------------------------------------------
interface llfl_rsp_if
	import llfl_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== hdl/linked_list_free_list_store.sv =====
// ----------------------------------------------------------------------------
// linked_list_free_list_store
// Insert: the slot comes off the free list, with an extra pop step, or else
// from the never-used pointer; the node is linked in front of the head.
// Remove: one node per cycle through the registered read port of the node
// store, at most NODE_COUNT nodes; a hit is unlinked and freed. A full store
// or an empty list answers straight from dispatch. One request is in work at
// a time; the next is taken in the cycle after the result is loaded. Reset
// empties both lists and the never-used pointer at once; the node memories are not cleared.
// ----------------------------------------------------------------------------
module linked_list_free_list_store
	import llfl_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	llfl_req_if.sink   req,
	llfl_rsp_if.source rsp
);

	llfl_cmd_t cmd;
	llfl_sts_t sts;

	// Sequencer
	llfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Store and pointers
	llfl_dp #(
		.NODE_COUNT (NODE_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.req_key     (req.key),
		.req_payload (req.payload),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.rsp_status  (rsp.status),
		.rsp_slot    (rsp.slot)
	);

endmodule

// ===== hdl/llfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// llfl_ctrl
// Sequencer for insert and remove requests. Drives datapath commands from
// datapath status; one request is in work at a time.
// ----------------------------------------------------------------------------
module llfl_ctrl
	import llfl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output llfl_cmd_t cmd,
	input  llfl_sts_t sts
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_INS_POP  = 3'd2;
	localparam logic [2:0] S_INS_WR   = 3'd3;
	localparam logic [2:0] S_RM_CHK   = 3'd4;
	localparam logic [2:0] S_RM_FREE  = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!sts.req_remove) begin
					if (!sts.free_empty) begin
						cmd.ins_take_free = 1'b1;
						state_d           = S_INS_POP;
					end else if (!sts.unused_full) begin
						cmd.ins_take_unused = 1'b1;
						state_d             = S_INS_WR;
					end else begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_FULL;
						state_d      = S_DONE;
					end
				end else if (sts.list_empty) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					cmd.rm_start = 1'b1;
					state_d      = S_RM_CHK;
				end
			end
			S_INS_POP: begin
				cmd.pop_free = 1'b1;
				state_d      = S_INS_WR;
			end
			S_INS_WR: begin
				cmd.ins_write = 1'b1;
				cmd.set_res   = 1'b1;
				cmd.res_code  = ST_DONE;
				state_d       = S_DONE;
			end
			// Compare one node per cycle; the next read is issued meanwhile
			S_RM_CHK: begin
				if (sts.key_hit) begin
					cmd.rm_unlink = 1'b1;
					state_d       = S_RM_FREE;
				end else if (sts.link_nil || sts.walk_last) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					cmd.rm_advance = 1'b1;
				end
			end
			S_RM_FREE: begin
				cmd.rm_free  = 1'b1;
				cmd.set_res  = 1'b1;
				cmd.res_code = ST_DONE;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/llfl_dp.sv =====
// ----------------------------------------------------------------------------
// llfl_dp
// Node store memories, list and free-list pointers, walk registers and the
// result register.
// ----------------------------------------------------------------------------
module llfl_dp
	import llfl_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  llfl_cmd_t             cmd,
	output llfl_sts_t             sts,
	input  logic                  req_type,
	input  logic [KEY_W-1:0]      req_key,
	input  logic [PAYLOAD_W-1:0]  req_payload,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [STATUS_W-1:0]   rsp_status,
	output logic [SLOT_OUT_W-1:0] rsp_slot
);

	localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int PTR_W  = $clog2(NODE_COUNT + 1);
	localparam logic [PTR_W-1:0]  NIL       = PTR_W'(NODE_COUNT);
	localparam logic [SLOT_W-1:0] STEP_LAST = SLOT_W'(NODE_COUNT - 1);

	// Node store
	logic [KEY_W-1:0]     key_mem     [NODE_COUNT];
	logic [PAYLOAD_W-1:0] payload_mem [NODE_COUNT];
	logic [PTR_W-1:0]     link_mem    [NODE_COUNT];

	logic [PTR_W-1:0]      list_head_q;
	logic [PTR_W-1:0]      free_head_q;
	logic [PTR_W-1:0]      next_unused_q;
	logic [SLOT_W-1:0]     cur_q;
	logic [PTR_W-1:0]      prev_q;
	logic [SLOT_W-1:0]     steps_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  req_type_q;
	logic [KEY_W-1:0]      req_key_q;
	logic [PAYLOAD_W-1:0]  req_payload_q;
	logic [STATUS_W-1:0]   res_q;
	logic [KEY_W-1:0]      key_rd_q;
	logic [PTR_W-1:0]      link_rd_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;

	logic                  rd_en;
	logic [SLOT_W-1:0]     rd_addr;
	logic                  link_we;
	logic [SLOT_W-1:0]     link_wa;
	logic [PTR_W-1:0]      link_wd;
	logic                  prev_nil;
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

	assign prev_nil = (prev_q == NIL);

	// Select read address: free-list head, list head or the link just read
	assign rd_en = cmd.ins_take_free | cmd.rm_start | cmd.rm_advance;
	always_comb begin
		if (cmd.ins_take_free) begin
			rd_addr = free_head_q[SLOT_W-1:0];
		end else if (cmd.rm_start) begin
			rd_addr = list_head_q[SLOT_W-1:0];
		end else begin
			rd_addr = link_rd_q[SLOT_W-1:0];
		end
	end

	// Select link write: new node, unlink in the middle, or free-list push
	assign link_we = cmd.ins_write | (cmd.rm_unlink & ~prev_nil) | cmd.rm_free;
	always_comb begin
		if (cmd.ins_write) begin
			link_wa = slot_q;
			link_wd = list_head_q;
		end else if (cmd.rm_free) begin
			link_wa = cur_q;
			link_wd = free_head_q;
		end else begin
			link_wa = prev_q[SLOT_W-1:0];
			link_wd = link_rd_q;
		end
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			key_mem[slot_q]     <= req_key_q;
			payload_mem[slot_q] <= req_payload_q;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (rd_en) begin
			key_rd_q  <= key_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
	end

	// Hold request, walk position and chosen slot
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_type_q    <= req_type;
			req_key_q     <= req_key;
			req_payload_q <= req_payload;
		end
		if (cmd.ins_take_free) begin
			slot_q <= free_head_q[SLOT_W-1:0];
		end else if (cmd.ins_take_unused) begin
			slot_q <= next_unused_q[SLOT_W-1:0];
		end else if (cmd.rm_free) begin
			slot_q <= cur_q;
		end
		if (cmd.rm_start) begin
			cur_q   <= list_head_q[SLOT_W-1:0];
			prev_q  <= NIL;
			steps_q <= '0;
		end else if (cmd.rm_advance) begin
			cur_q   <= link_rd_q[SLOT_W-1:0];
			prev_q  <= PTR_W'(cur_q);
			steps_q <= steps_q + SLOT_W'(1);
		end
		if (cmd.set_res) begin
			res_q <= cmd.res_code;
		end
	end

	// Update list head, free-list head and never-used pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q   <= NIL;
			free_head_q   <= NIL;
			next_unused_q <= '0;
		end else begin
			if (cmd.ins_take_unused) begin
				next_unused_q <= next_unused_q + PTR_W'(1);
			end
			if (cmd.pop_free) begin
				free_head_q <= link_rd_q;
			end else if (cmd.rm_free) begin
				free_head_q <= PTR_W'(cur_q);
			end
			if (cmd.ins_write) begin
				list_head_q <= PTR_W'(slot_q);
			end else if (cmd.rm_unlink && prev_nil) begin
				list_head_q <= link_rd_q;
			end
		end
	end

	// Result register; slot reads zero unless the request succeeded
	assign slot_wide = {{SLOT_OUT_W{1'b0}}, slot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_q;
			out_slot_q   <= (res_q == ST_DONE) ? slot_wide[SLOT_OUT_W-1:0] : '0;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot   = out_slot_q;

	// Status toward the controller
	always_comb begin
		sts.req_remove  = (req_type_q == REQ_REMOVE);
		sts.free_empty  = (free_head_q == NIL);
		sts.unused_full = (next_unused_q == NIL);
		sts.list_empty  = (list_head_q == NIL);
		sts.key_hit     = (key_rd_q == req_key_q);
		sts.link_nil    = (link_rd_q == NIL);
		sts.walk_last   = (steps_q == STEP_LAST);
		sts.out_free    = ~out_valid_q | rsp_ready;
	end

endmodule

// ===== hdl/llfl_checker.sv =====
// ----------------------------------------------------------------------------
// llfl_checker
// Port-level checks of the node store: request/result balance, status
// coding and result hold under stall.
// ----------------------------------------------------------------------------
module llfl_checker
	import llfl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [STATUS_W-1:0]   rsp_status,
	input logic [SLOT_OUT_W-1:0] rsp_slot
);

	logic [1:0] pending_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid & req_ready;
	assign rsp_acc = rsp_valid & rsp_ready;

	// Count requests taken whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("result without an open request");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests open");

	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ST_DONE) |->
			(rsp_slot == '0 && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)))
		else $error("bad status or nonzero slot on failed request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_slot)))
		else $error("stalled result changed");

endmodule

bind linked_list_free_list_store llfl_checker u_llfl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_slot   (rsp.slot)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives insert and remove requests into the linked-list node store and
// checks each status/slot result against a cycle-free mirror of the store:
// its live list, free list and never-used pointer. Covers empty-list
// removes, head and middle unlinks, duplicate keys, free-slot reuse, a
// completely full store and long random traffic under sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import llfl_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;
	localparam int IDX_W = $clog2(NODES + 1);
	localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);
	localparam int RANDOM_ITEMS = 220;

	typedef logic [IDX_W-1:0] node_idx_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
	} result_t;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_LONG_STALL} rdy_mode_t;

	logic clk;
	logic arst_n;

	llfl_req_if req_ch();
	llfl_rsp_if rsp_ch();

	linked_list_free_list_store u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Mirror of the node store
	node_idx_t              mirror_head   = NIL;
	node_idx_t              mirror_free   = NIL;
	node_idx_t              mirror_unused = '0;
	int                     mirror_live   = 0;
	node_idx_t              mirror_link [NODES];
	logic [KEY_W-1:0]       mirror_key  [NODES];
	logic [PAYLOAD_W-1:0]   mirror_data [NODES];

	result_t pending_results[$];
	int      mismatches = 0;
	int      burst_left = 0;

	// Take a slot, fill it and link it in front of the head
	function automatic result_t store_insert(logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] d);
		node_idx_t s;
		result_t   r;
		if (mirror_free != NIL) begin
			s = mirror_free;
			mirror_free = mirror_link[s];
		end else if (mirror_unused != NIL) begin
			s = mirror_unused;
			mirror_unused = mirror_unused + 1'b1;
		end else begin
			r.status = ST_FULL;
			r.slot   = '0;
			return r;
		end
		mirror_key[s]  = k;
		mirror_data[s] = d;
		mirror_link[s] = mirror_head;
		mirror_head    = s;
		mirror_live++;
		r.status = ST_DONE;
		r.slot   = s[SLOT_OUT_W-1:0];
		return r;
	endfunction

	// Walk for the first matching key, unlink it and push it on the free list
	function automatic result_t store_remove(logic [KEY_W-1:0] k);
		node_idx_t cur;
		node_idx_t prev;
		int        steps;
		result_t   r;
		cur   = mirror_head;
		prev  = NIL;
		steps = 0;
		while (cur != NIL && steps < NODES) begin
			if (mirror_key[cur] == k) begin
				if (prev == NIL)
					mirror_head = mirror_link[cur];
				else
					mirror_link[prev] = mirror_link[cur];
				mirror_link[cur] = mirror_free;
				mirror_free = cur;
				mirror_live--;
				r.status = ST_DONE;
				r.slot   = cur[SLOT_OUT_W-1:0];
				return r;
			end
			prev = cur;
			cur  = mirror_link[cur];
			steps++;
		end
		r.status = ST_NOT_FOUND;
		r.slot   = '0;
		return r;
	endfunction

	// Key of the live node at a given depth from the head
	function automatic logic [KEY_W-1:0] live_key_at(int depth);
		node_idx_t cur;
		cur = mirror_head;
		for (int i = 0; i < depth && mirror_link[cur] != NIL; i++)
			cur = mirror_link[cur];
		return mirror_key[cur];
	endfunction

	function automatic bit key_is_live(logic [KEY_W-1:0] k);
		node_idx_t cur;
		cur = mirror_head;
		while (cur != NIL) begin
			if (mirror_key[cur] == k)
				return 1'b1;
			cur = mirror_link[cur];
		end
		return 1'b0;
	endfunction

	// Small pool for duplicates, extremes now and then, else the full range
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return KEY_W'($urandom_range(0, 15));
		if (roll < 55)
			return '0;
		if (roll < 60)
			return '1;
		return KEY_W'($urandom_range(0, 65535));
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hold the request until accepted; record the predicted result on accept
	task automatic send_request(logic op, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.key      <= k;
		req_ch.payload  <= d;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (op == REQ_INSERT)
			pending_results.push_back(store_insert(k, d));
		else
			pending_results.push_back(store_remove(k));
	endtask

	// Drop valid and hold until every outstanding result is back
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Removes from an empty list
	task automatic test_empty_remove();
		send_request(REQ_REMOVE, '0, $urandom());
		send_request(REQ_REMOVE, '1, $urandom());
	endtask

	// Head and middle unlinks, duplicates, free-slot reuse
	task automatic test_link_order();
		send_request(REQ_INSERT, 16'h0000, 32'h0000_0000);
		send_request(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 16'h1234, 32'hA5A5_5A5A);
		send_request(REQ_INSERT, 16'h0000, 32'h5A5A_A5A5);
		send_request(REQ_REMOVE, 16'hFFFF, $urandom());
		send_request(REQ_REMOVE, 16'h0000, $urandom());
		send_request(REQ_REMOVE, 16'h0000, $urandom());
		send_request(REQ_REMOVE, 16'h0000, $urandom());
		send_request(REQ_REMOVE, 16'h5555, $urandom());
		send_request(REQ_REMOVE, 16'h1234, $urandom());
		send_request(REQ_REMOVE, 16'h1234, $urandom());
		send_request(REQ_INSERT, 16'h0007, $urandom());
		send_request(REQ_INSERT, 16'h0008, $urandom());
		send_request(REQ_INSERT, 16'h0007, $urandom());
		send_request(REQ_REMOVE, 16'h0007, $urandom());
		send_request(REQ_REMOVE, 16'h0008, $urandom());
		send_request(REQ_REMOVE, 16'h0007, $urandom());
	endtask

	// Fill every slot, overflow, walk the full list, then empty it
	task automatic test_full_store();
		logic [KEY_W-1:0] k;
		while (!(mirror_free == NIL && mirror_unused == NIL))
			send_request(REQ_INSERT, KEY_W'($urandom_range(0, 65535)), $urandom());
		repeat (3) send_request(REQ_INSERT, pick_key(), $urandom());
		do
			k = KEY_W'($urandom_range(0, 65535));
		while (key_is_live(k));
		send_request(REQ_REMOVE, k, $urandom());
		send_request(REQ_REMOVE, live_key_at(NODES - 1), $urandom());
		send_request(REQ_INSERT, pick_key(), $urandom());
		send_request(REQ_INSERT, pick_key(), $urandom());
		while (mirror_live > 0)
			send_request(REQ_REMOVE, live_key_at($urandom_range(0, mirror_live - 1)),
				$urandom());
	endtask

	// Mostly removes of live keys and inserts, with some misses mixed in
	task automatic test_random_traffic(int count);
		int roll;
		int ins_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 250 == 125)
				wait_for_results();
			ins_pct = (mirror_live < 8) ? 75 : ((mirror_live > 48) ? 30 : 50);
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				send_request(REQ_INSERT, pick_key(), $urandom());
			else if (roll < 90 && mirror_live > 0)
				send_request(REQ_REMOVE, live_key_at($urandom_range(0, mirror_live - 1)),
					$urandom());
			else
				send_request(REQ_REMOVE, pick_key(), $urandom());
		end
	endtask

	// Receiver: switch at random among ready patterns
	initial begin : rsp_stall
		rdy_mode_t mode;
		int        left;
		mode = RDY_ALWAYS;
		left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = rdy_mode_t'($urandom_range(0, 3));
				left = $urandom_range(8, 80);
			end
			left--;
			case (mode)
				RDY_ALWAYS: rsp_ch.ready <= 1'b1;
				RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default:    rsp_ch.ready <= (left % 10 == 0);
			endcase
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d slot %0d", rsp_ch.status, rsp_ch.slot);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d",
						want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.slot !== want.slot) begin
					$error("slot mismatch: expected %0d, actual %0d", want.slot, rsp_ch.slot);
					mismatches++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_INSERT;
		req_ch.key      <= '0;
		req_ch.payload  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_remove();
		test_link_order();
		wait_for_results();
		test_full_store();
		wait_for_results();
		test_random_traffic(RANDOM_ITEMS);

		// Let the last remove finish its walk
		wait_for_results();
		repeat (NODES + 16) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== linked_list_free_list_store.f =====
hdl/llfl_pkg.sv
hdl/llfl_req_if.sv
hdl/llfl_rsp_if.sv
hdl/llfl_ctrl.sv
hdl/llfl_dp.sv
hdl/linked_list_free_list_store.sv
hdl/llfl_checker.sv
dv/testbench.sv
